[sv/gyro_rotation_integrator_macros.svh]
// assertion macros for the gyro rotation integrator
// used by the top level only, no other dependencies
`ifndef GYRO_ROTATION_INTEGRATOR_MACROS_SVH
`define GYRO_ROTATION_INTEGRATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define GRI_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define GRI_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[sv/gri_pkg.sv]
// shared constants, arctangent table, index helper and command struct
// no dependencies
package gri_pkg;

   localparam int ATAN_COUNT = 30;
   localparam logic signed [31:0] ONE_Q30 = 32'sh4000_0000;
   localparam logic [35:0] HALF_PI_Q30 = 36'd1686629713;
   localparam logic [35:0] QUARTER_PI_Q30 = 36'd843314856;
   localparam logic signed [33:0] CORDIC_GAIN_INV = 34'sd652032874;
   localparam logic [4:0] MAC_ISSUES = 5'd27;
   localparam logic [4:0] MAC_LAST = 5'd29;
   localparam logic [1:0] PH_RY = 2'd0;
   localparam logic [1:0] PH_RZ = 2'd1;
   localparam logic [1:0] PH_ACC = 2'd2;

   typedef struct packed {
      logic       load_in;
      logic       angle;
      logic       reduce;
      logic [2:0] red_bit;
      logic       prep;
      logic       cordic;
      logic [4:0] step;
      logic       sincos;
      logic       mac_issue;
      logic [1:0] phase;
      logic [1:0] row;
      logic [1:0] col;
      logic [1:0] kk;
      logic       copy_a;
      logic       commit;
      logic       emit;
   } gri_cmd_type;

   function automatic logic signed [33:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0:  atan_q30 = 34'sh3243F6A8;
         5'd1:  atan_q30 = 34'sh1DAC6705;
         5'd2:  atan_q30 = 34'sh0FADBAFC;
         5'd3:  atan_q30 = 34'sh07F56EA6;
         5'd4:  atan_q30 = 34'sh03FEAB76;
         5'd5:  atan_q30 = 34'sh01FFD55B;
         5'd6:  atan_q30 = 34'sh00FFFAAA;
         5'd7:  atan_q30 = 34'sh007FFF55;
         5'd8:  atan_q30 = 34'sh003FFFEA;
         5'd9:  atan_q30 = 34'sh001FFFFD;
         5'd10: atan_q30 = 34'sh000FFFFF;
         5'd11: atan_q30 = 34'sh0007FFFF;
         5'd12: atan_q30 = 34'sh0003FFFF;
         5'd13: atan_q30 = 34'sh0001FFFF;
         5'd14: atan_q30 = 34'sh0000FFFF;
         5'd15: atan_q30 = 34'sh00007FFF;
         5'd16: atan_q30 = 34'sh00003FFF;
         5'd17: atan_q30 = 34'sh00001FFF;
         5'd18: atan_q30 = 34'sh00000FFF;
         5'd19: atan_q30 = 34'sh000007FF;
         5'd20: atan_q30 = 34'sh000003FF;
         5'd21: atan_q30 = 34'sh000001FF;
         5'd22: atan_q30 = 34'sh000000FF;
         5'd23: atan_q30 = 34'sh0000007F;
         5'd24: atan_q30 = 34'sh0000003F;
         5'd25: atan_q30 = 34'sh0000001F;
         5'd26: atan_q30 = 34'sh0000000F;
         5'd27: atan_q30 = 34'sh00000007;
         5'd28: atan_q30 = 34'sh00000003;
         5'd29: atan_q30 = 34'sh00000001;
         default: atan_q30 = 34'sh0;
      endcase
   endfunction

   // row-major index of a 3x3 entry
   function automatic logic [3:0] idx3(input logic [1:0] r, input logic [1:0] c);
      idx3 = {1'b0, r, 1'b0} + {2'b0, r} + {2'b0, c};
   endfunction

endpackage

[sv/gri_datapath.sv]
// angle forming, quadrant reduction, cordic lanes and matrix multiply-accumulate
// depends on gri_pkg
module gri_datapath import gri_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  gri_cmd_type        cmd,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   input  logic [15:0]        req_time_step,
   output logic signed [31:0] rsp_r00,
   output logic signed [31:0] rsp_r01,
   output logic signed [31:0] rsp_r02,
   output logic signed [31:0] rsp_r10,
   output logic signed [31:0] rsp_r11,
   output logic signed [31:0] rsp_r12,
   output logic signed [31:0] rsp_r20,
   output logic signed [31:0] rsp_r21,
   output logic signed [31:0] rsp_r22
);

   function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
      if (v > 34'sd1073741824)
         sat32 = ONE_Q30;
      else if (v < -34'sd1073741824)
         sat32 = -ONE_Q30;
      else
         sat32 = v[31:0];
   endfunction

   logic signed [15:0] gyro_ff [3];
   logic [15:0]        dt_ff;
   logic [35:0]        rem_ff [3];
   logic [4:0]         quo_ff [3];
   logic               neg_ff [3];
   logic [1:0]         quad_ff [3];
   logic signed [33:0] x_ff [3];
   logic signed [33:0] y_ff [3];
   logic signed [33:0] z_ff [3];
   logic signed [31:0] cos_ff [3];
   logic signed [31:0] sin_ff [3];

   logic [15:0]        mag_w [3];
   logic [35:0]        thr_w;
   logic signed [33:0] diff_w [3];
   logic signed [31:0] xs_w [3];
   logic signed [31:0] ys_w [3];
   logic signed [33:0] atan_w;

   always_comb begin
      thr_w = HALF_PI_Q30 << cmd.red_bit;
      atan_w = atan_q30(cmd.step);
      for (int l = 0; l < 3; l++) begin
         mag_w[l] = gyro_ff[l][15] ? 16'(~gyro_ff[l] + 16'd1) : gyro_ff[l];
         diff_w[l] = $signed({2'b00, rem_ff[l][31:0]})
                     - $signed({2'b00, QUARTER_PI_Q30[31:0]});
         xs_w[l] = sat32(x_ff[l]);
         ys_w[l] = sat32(y_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_in) begin
         gyro_ff[0] <= req_gyro_x;
         gyro_ff[1] <= req_gyro_y;
         gyro_ff[2] <= req_gyro_z;
         dt_ff <= req_time_step;
      end
      for (int l = 0; l < 3; l++) begin
         if (cmd.angle) begin
            rem_ff[l] <= {{16'd0, mag_w[l]} * {16'd0, dt_ff}, 4'b0000} + QUARTER_PI_Q30;
            quo_ff[l] <= 5'd0;
            neg_ff[l] <= gyro_ff[l][15];
         end
         if (cmd.reduce && rem_ff[l] >= thr_w) begin
            rem_ff[l] <= rem_ff[l] - thr_w;
            quo_ff[l][cmd.red_bit] <= 1'b1;
         end
         if (cmd.prep) begin
            x_ff[l] <= CORDIC_GAIN_INV;
            y_ff[l] <= '0;
            z_ff[l] <= neg_ff[l] ? -diff_w[l] : diff_w[l];
            quad_ff[l] <= neg_ff[l] ? 2'(~quo_ff[l] + 5'd1) : quo_ff[l][1:0];
         end
         if (cmd.cordic) begin
            if (!z_ff[l][33]) begin
               x_ff[l] <= x_ff[l] - (y_ff[l] >>> cmd.step);
               y_ff[l] <= y_ff[l] + (x_ff[l] >>> cmd.step);
               z_ff[l] <= z_ff[l] - atan_w;
            end else begin
               x_ff[l] <= x_ff[l] + (y_ff[l] >>> cmd.step);
               y_ff[l] <= y_ff[l] - (x_ff[l] >>> cmd.step);
               z_ff[l] <= z_ff[l] + atan_w;
            end
         end
         if (cmd.sincos) begin
            case (quad_ff[l])
               2'd0: begin
                  cos_ff[l] <= xs_w[l];
                  sin_ff[l] <= ys_w[l];
               end
               2'd1: begin
                  cos_ff[l] <= -ys_w[l];
                  sin_ff[l] <= xs_w[l];
               end
               2'd2: begin
                  cos_ff[l] <= -xs_w[l];
                  sin_ff[l] <= -ys_w[l];
               end
               default: begin
                  cos_ff[l] <= ys_w[l];
                  sin_ff[l] <= -xs_w[l];
               end
            endcase
         end
      end
   end

   // matrix products, one multiply per cycle while the sequencer issues them
   logic signed [31:0] a_ff [9];
   logic signed [31:0] p_ff [9];
   logic signed [31:0] acc_ff [9];
   logic signed [31:0] out_ff [9];
   logic signed [63:0] prod_ff;
   logic signed [62:0] sum_ff;
   logic               v1_ff, v2_ff;
   logic               first1_ff, last1_ff;
   logic [3:0]         dst1_ff, dst2_ff;

   logic [3:0]         ia_w, ib_w;
   logic signed [31:0] a_w, b_w;
   logic signed [62:0] add_w;
   logic signed [32:0] rnd_w;

   always_comb begin
      ia_w = idx3(cmd.row, cmd.kk);
      ib_w = idx3(cmd.kk, cmd.col);
      if (cmd.phase == PH_RY) begin
         case (ia_w)
            4'd0: a_w = ONE_Q30;
            4'd4: a_w = cos_ff[0];
            4'd5: a_w = sin_ff[0];
            4'd7: a_w = -sin_ff[0];
            4'd8: a_w = cos_ff[0];
            default: a_w = '0;
         endcase
      end else begin
         a_w = a_ff[ia_w];
      end
      case (cmd.phase)
         PH_RY: begin
            case (ib_w)
               4'd0: b_w = cos_ff[1];
               4'd2: b_w = -sin_ff[1];
               4'd4: b_w = ONE_Q30;
               4'd6: b_w = sin_ff[1];
               4'd8: b_w = cos_ff[1];
               default: b_w = '0;
            endcase
         end
         PH_RZ: begin
            case (ib_w)
               4'd0: b_w = cos_ff[2];
               4'd1: b_w = sin_ff[2];
               4'd3: b_w = -sin_ff[2];
               4'd4: b_w = cos_ff[2];
               4'd8: b_w = ONE_Q30;
               default: b_w = '0;
            endcase
         end
         default: b_w = acc_ff[ib_w];
      endcase
      add_w = (first1_ff ? 63'sd0 : sum_ff) + prod_ff[62:0];
      rnd_w = 33'((sum_ff + 63'sd536870912) >>> 30);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.mac_issue;
         v2_ff <= v1_ff && last1_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_w * b_w;
      first1_ff <= (cmd.kk == 2'd0);
      last1_ff <= (cmd.kk == 2'd2);
      dst1_ff <= idx3(cmd.row, cmd.col);
      if (v1_ff) begin
         sum_ff <= add_w;
         dst2_ff <= dst1_ff;
      end
      if (v2_ff)
         p_ff[dst2_ff] <= sat32({rnd_w[32], rnd_w});
      if (cmd.copy_a)
         a_ff <= p_ff;
      if (cmd.commit && cmd.emit)
         out_ff <= p_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || (cmd.commit && cmd.emit)) begin
         for (int i = 0; i < 9; i++)
            acc_ff[i] <= (i == 0 || i == 4 || i == 8) ? ONE_Q30 : 32'sd0;
      end else if (cmd.commit) begin
         acc_ff <= p_ff;
      end
   end

   assign rsp_r00 = out_ff[0];
   assign rsp_r01 = out_ff[1];
   assign rsp_r02 = out_ff[2];
   assign rsp_r10 = out_ff[3];
   assign rsp_r11 = out_ff[4];
   assign rsp_r12 = out_ff[5];
   assign rsp_r20 = out_ff[6];
   assign rsp_r21 = out_ff[7];
   assign rsp_r22 = out_ff[8];

endmodule

[sv/gri_controller.sv]
// sequencer: input handshake, step counters, result valid
// depends on gri_pkg
module gri_controller import gri_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_end_of_scan,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output gri_cmd_type cmd
);

   localparam int NUM_STEPS = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
   localparam logic [4:0] LAST_STEP = 5'(NUM_STEPS - 1);

   localparam logic [2:0] S_IDLE   = 3'd0;
   localparam logic [2:0] S_ANGLE  = 3'd1;
   localparam logic [2:0] S_REDUCE = 3'd2;
   localparam logic [2:0] S_PREP   = 3'd3;
   localparam logic [2:0] S_CORDIC = 3'd4;
   localparam logic [2:0] S_SINCOS = 3'd5;
   localparam logic [2:0] S_MUL    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [4:0] cnt_ff, cnt_in;
   logic [1:0] phase_ff, phase_in;
   logic [1:0] row_ff, row_in, col_ff, col_in, kk_ff, kk_in;
   logic       eos_ff, eos_in;
   logic       valid_ff, valid_in;

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      phase_in = phase_ff;
      row_in = row_ff;
      col_in = col_ff;
      kk_in = kk_ff;
      eos_in = eos_ff;
      valid_in = valid_ff && !rsp_ready;
      req_ready = 1'b0;
      cmd = '0;
      cmd.phase = phase_ff;
      cmd.row = row_ff;
      cmd.col = col_ff;
      cmd.kk = kk_ff;
      cmd.step = cnt_ff;
      cmd.red_bit = 3'(3'd4 - cnt_ff[2:0]);
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_in = 1'b1;
               eos_in = req_end_of_scan;
               state_in = S_ANGLE;
            end
         end
         S_ANGLE: begin
            cmd.angle = 1'b1;
            cnt_in = '0;
            state_in = S_REDUCE;
         end
         S_REDUCE: begin
            cmd.reduce = 1'b1;
            if (cnt_ff == 5'd4) begin
               cnt_in = '0;
               state_in = S_PREP;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_PREP: begin
            cmd.prep = 1'b1;
            state_in = S_CORDIC;
         end
         S_CORDIC: begin
            cmd.cordic = 1'b1;
            if (cnt_ff == LAST_STEP) begin
               cnt_in = '0;
               state_in = S_SINCOS;
            end else begin
               cnt_in = cnt_ff + 5'd1;
            end
         end
         S_SINCOS: begin
            cmd.sincos = 1'b1;
            cnt_in = '0;
            phase_in = PH_RY;
            row_in = '0;
            col_in = '0;
            kk_in = '0;
            state_in = S_MUL;
         end
         S_MUL: begin
            cmd.mac_issue = (cnt_ff < MAC_ISSUES);
            if (cmd.mac_issue) begin
               kk_in = (kk_ff == 2'd2) ? 2'd0 : kk_ff + 2'd1;
               if (kk_ff == 2'd2) begin
                  col_in = (col_ff == 2'd2) ? 2'd0 : col_ff + 2'd1;
                  if (col_ff == 2'd2)
                     row_in = (row_ff == 2'd2) ? 2'd0 : row_ff + 2'd1;
               end
            end
            if (cnt_ff != MAC_LAST) begin
               cnt_in = cnt_ff + 5'd1;
            end else if (phase_ff != PH_ACC) begin
               cmd.copy_a = 1'b1;
               phase_in = phase_ff + 2'd1;
               cnt_in = '0;
            end else if (!(eos_ff && valid_ff && !rsp_ready)) begin
               // result register must be free before an end-of-scan commit
               cmd.commit = 1'b1;
               cmd.emit = eos_ff;
               if (eos_ff)
                  valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         phase_ff <= '0;
         row_ff <= '0;
         col_ff <= '0;
         kk_ff <= '0;
         eos_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         phase_ff <= phase_in;
         row_ff <= row_in;
         col_ff <= col_in;
         kk_ff <= kk_in;
         eos_ff <= eos_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid = valid_ff;

endmodule

[sv/gyro_rotation_integrator.sv]
// one item at a time: a new item is accepted only after the previous one has finished, since the single
// shared multiply-accumulate runs three 3x3 products (81 multiplies plus drain) per item, and an
// end-of-scan commit waits while an unread result is still held
// reset: synchronous, active high; stored rotation returns to identity, no result pending
// top level: gri_controller sequences gri_datapath; uses gri_pkg and the macros header
module gyro_rotation_integrator import gri_pkg::*; #(
   parameter int CORDIC_STEPS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_gyro_x,
   input  logic signed [15:0] req_gyro_y,
   input  logic signed [15:0] req_gyro_z,
   input  logic [15:0]        req_time_step,
   input  logic               req_end_of_scan,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_r00,
   output logic signed [31:0] rsp_r01,
   output logic signed [31:0] rsp_r02,
   output logic signed [31:0] rsp_r10,
   output logic signed [31:0] rsp_r11,
   output logic signed [31:0] rsp_r12,
   output logic signed [31:0] rsp_r20,
   output logic signed [31:0] rsp_r21,
   output logic signed [31:0] rsp_r22
);

   // command bundle from the sequencer to the arithmetic
   gri_cmd_type cmd;

   // sequencer: one item in flight, the result register decouples the output side
   gri_controller #(
      .CORDIC_STEPS(CORDIC_STEPS)
   ) u_ctrl (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_end_of_scan(req_end_of_scan),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .cmd            (cmd)
   );

   // datapath: angle, quadrant reduction, three cordic lanes, matrix mac
   gri_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .req_gyro_x   (req_gyro_x),
      .req_gyro_y   (req_gyro_y),
      .req_gyro_z   (req_gyro_z),
      .req_time_step(req_time_step),
      .rsp_r00      (rsp_r00),
      .rsp_r01      (rsp_r01),
      .rsp_r02      (rsp_r02),
      .rsp_r10      (rsp_r10),
      .rsp_r11      (rsp_r11),
      .rsp_r12      (rsp_r12),
      .rsp_r20      (rsp_r20),
      .rsp_r21      (rsp_r21),
      .rsp_r22      (rsp_r22)
   );

`include "gyro_rotation_integrator_macros.svh"

   // an accepted item keeps the input side closed on the next cycle
   `GRI_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready, "input open right after accept")

   // a new result only appears at the end of an item's work
   `GRI_ASSERT_NOW(a_emit_from_work, clock, reset, $rose(rsp_valid), $past(!req_ready), "result without item in flight")

   // emitted r00 stays within saturation bounds
   `GRI_ASSERT_NOW(a_diag_range, clock, reset, rsp_valid, (rsp_r00 <= 32'sh4000_0000) && (rsp_r00 >= -32'sh4000_0000), "r00 out of range")

endmodule
